### sv/cfps_pkg.sv
// Shared types and constants for the color filter pulse sequencer.
package cfps_pkg;

  localparam int CountWidthDefault = 16;
  localparam int CfgDataWidth      = 16;
  localparam int CfgAddrWidth      = 1;
  localparam int TickWidth         = 16;
  localparam int PulseWidth        = 16;

  // Configuration register indexes
  localparam logic [CfgAddrWidth-1:0] CFG_SETTLE_IDX = 1'd0;
  localparam logic [CfgAddrWidth-1:0] CFG_WINDOW_IDX = 1'd1;

  localparam logic [TickWidth-1:0] SETTLE_RESET = 16'd2000;
  localparam logic [TickWidth-1:0] WINDOW_RESET = 16'd10000;

  // Filter codes
  localparam logic [1:0] FILTER_CLEAR = 2'd0;
  localparam logic [1:0] FILTER_BLUE  = 2'd3;

  typedef struct packed {
    logic start_req;
    logic sensor_level;
  } in_word_t;

  typedef struct packed {
    logic                  select_s2;
    logic                  select_s3;
    logic                  busy_res;
    logic                  count_valid;
    logic [1:0]            channel;
    logic [PulseWidth-1:0] pulse_count;
    logic                  last;
  } out_word_t;

endpackage

### sv/color_filter_pulse_sequencer.sv
// Color filter pulse sequencer: filter stepping, settle wait and edge counting.
//
//   channel | handshake          | word
//   --------+--------------------+-------------------------------------------
//   in      | in_valid/in_ready  | in_word_t: start request, sensor level
//   out     | out_valid/out_ready| out_word_t: selects, busy, count result
//   cfg     | cfg_we             | cfg_addr selects settle or window ticks
//
// One input word per cycle while in_ready is high; each accepted word yields one
// output word in the following cycle, from the single output register.
// in_ready is high whenever the output register is empty or being drained,
// so a stalled consumer stalls the input only while a word is waiting.
// Reset (synchronous, rst_n low) returns to idle with the clear filter
// selected and the config registers at 2000 settle / 10000 window ticks.
module color_filter_pulse_sequencer #(
  parameter int COUNT_WIDTH = cfps_pkg::CountWidthDefault
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  cfps_pkg::in_word_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output cfps_pkg::out_word_t                   out_word,
  input  logic                                  cfg_we,
  input  logic [cfps_pkg::CfgAddrWidth-1:0]     cfg_addr,
  input  logic [cfps_pkg::CfgDataWidth-1:0]     cfg_wdata
);
  import cfps_pkg::*;

  // Edge total saturates at the counter max, never beyond 16 bits.
  localparam int EdgeW = (COUNT_WIDTH < PulseWidth) ? COUNT_WIDTH : PulseWidth;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SETTLE,
    PH_REF,
    PH_COUNT
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [1:0]             filter_r, filter_nxt;
  logic [TickWidth-1:0]   tick_r, tick_nxt;
  logic [EdgeW-1:0]       edge_r, edge_nxt;
  logic                   prev_r, prev_nxt;
  logic [TickWidth-1:0]   settle_r;
  logic [TickWidth-1:0]   window_r;
  logic                   out_valid_r;
  out_word_t              out_word_r, out_word_nxt;

  logic                   in_fire;
  logic                   take_ref;
  logic [TickWidth-1:0]   tick_inc;
  logic                   win_done;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Saturating tick advance used by the counting window.
  assign tick_inc = (tick_r == '1) ? tick_r : tick_r + 16'd1;
  assign win_done = tick_inc >= window_r;

  always_comb begin
    phase_nxt    = phase_r;
    filter_nxt   = filter_r;
    tick_nxt     = tick_r;
    edge_nxt     = edge_r;
    prev_nxt     = prev_r;
    take_ref     = 1'b0;
    out_word_nxt = '0;

    unique case (phase_r)
      PH_IDLE: begin
        if (in_data.start_req) begin
          filter_nxt = FILTER_CLEAR;
          tick_nxt   = '0;
          phase_nxt  = PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        if (tick_r < settle_r) begin
          tick_nxt = tick_r + 16'd1;
        end else begin
          // settle done: reference sample taken on this same tick
          take_ref = 1'b1;
        end
      end
      PH_REF: begin
        take_ref = 1'b1;
      end
      PH_COUNT: begin
        if (in_data.sensor_level && !prev_r && (edge_r != '1)) begin
          edge_nxt = edge_r + EdgeW'(1);
        end
        prev_nxt = in_data.sensor_level;
        tick_nxt = tick_inc;
        if (win_done) begin
          out_word_nxt.count_valid = 1'b1;
          out_word_nxt.channel     = filter_r;
          out_word_nxt.pulse_count = PulseWidth'(edge_nxt);
          out_word_nxt.last        = (filter_r == FILTER_BLUE);
          tick_nxt                 = '0;
          if (filter_r == FILTER_BLUE) begin
            filter_nxt = FILTER_CLEAR;
            phase_nxt  = PH_IDLE;
          end else begin
            filter_nxt = filter_r + 2'd1;
            phase_nxt  = PH_SETTLE;
          end
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase

    if (take_ref) begin
      prev_nxt  = in_data.sensor_level;
      tick_nxt  = '0;
      edge_nxt  = '0;
      phase_nxt = PH_COUNT;
    end

    // S2 high for green/blue, S3 high for clear/green
    out_word_nxt.select_s2 = filter_nxt[1];
    out_word_nxt.select_s3 = ~filter_nxt[0];
    out_word_nxt.busy_res  = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      filter_r    <= FILTER_CLEAR;
      tick_r      <= '0;
      edge_r      <= '0;
      prev_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r     <= phase_nxt;
        filter_r    <= filter_nxt;
        tick_r      <= tick_nxt;
        edge_r      <= edge_nxt;
        prev_r      <= prev_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_word_r <= out_word_nxt;
    end
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_RESET;
      window_r <= WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SETTLE_IDX: settle_r <= cfg_wdata;
        CFG_WINDOW_IDX: window_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

### sv/cfps_checker.sv
// Port-level checker for the color filter pulse sequencer, with its bind.
module cfps_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input cfps_pkg::out_word_t  out_word
);
  import cfps_pkg::*;

  // Output register empties on reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A waiting word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  // Full output register with a stalled consumer blocks the input.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // Last only on a completed blue count.
  a_last_blue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last |->
      out_word.count_valid && (out_word.channel == FILTER_BLUE))
    else $error("last without blue count");

  // Idle selects the clear filter; non-final counts leave it busy.
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!out_word.busy_res || (out_word.count_valid && !out_word.last)) |->
      (out_word.busy_res || (!out_word.select_s2 && out_word.select_s3)) &&
      (!out_word.count_valid || out_word.last || out_word.busy_res))
    else $error("idle select or busy flag wrong");

endmodule

bind color_filter_pulse_sequencer cfps_checker u_cfps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
